// ===== rtl/cra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_pkg: shared types and constants of the complex register ALU
// Register count, fixed-point format, operation codes and the command type.
// ----------------------------------------------------------------------------
package cra_pkg;

  localparam int NumRegisters = 6;
  localparam int FracBits     = 16;
  localparam int IdxW         = 3;
  localparam int AddrW        = $clog2(NumRegisters);

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_SHOW  = 3'd1,
    OP_ADD   = 3'd2,
    OP_SUB   = 3'd3,
    OP_SCRE  = 3'd4,
    OP_SCIM  = 3'd5,
    OP_CMUL  = 3'd6,
    OP_MAG   = 3'd7
  } op_e;

  typedef struct packed {
    logic        [31:0] scalar_second;
    logic        [31:0] scalar_first;
    logic [IdxW-1:0]    source_index;
    logic [IdxW-1:0]    target_index;
    op_e                kind;
  } cmd_t;

  typedef struct packed {
    logic        saturated;
    logic        is_magnitude;
    logic [31:0] magnitude;
    logic [31:0] result_imag;
    logic [31:0] result_real;
  } res_t;

  // Round-to-nearest (ties up) Q product of a 64-bit raw product.
  function automatic logic signed [48:0] qround(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + (64'sd1 <<< (FracBits - 1));
    return {s[63], s[63:FracBits]};
  endfunction

  function automatic logic [32:0] clip32(input logic signed [49:0] v);
    logic [32:0] r;
    if (v > 50'sd2147483647) r = {1'b1, 32'h7fffffff};
    else if (v < -50'sd2147483648) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

// ===== rtl/cra_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_sqrt: bit-serial integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module cra_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import cra_pkg::*;

  logic [63:0] rem_q, rem_d;
  logic [63:0] res_q, res_d;
  logic [63:0] bit_q, bit_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] trial;

  assign trial = res_q + bit_q;

  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = radicand_i;
      res_d  = '0;
      bit_d  = 64'd1 << 62;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];
endmodule

// ===== rtl/complex_register_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_register_alu: six complex Q16.16 registers with an arithmetic unit
// Usage:
//   Commands enter on s_axis (tdata: kind, target, source, two scalars).
//   Results leave on m_axis (tdata: real, imag, magnitude; tuser: flags).
//   Load and commands naming an unused register give no result.
//   The register file is a synchronous RAM of one 64-bit word per register;
//   a command reads the target as it is taken, then the source, computes,
//   writes back (magnitude leaves the register as it is) and emits.
//   Steps: show/add/sub pass through target read, source read, execute and
//   output; the multiplies add four products through one 32x32
//   multiplier, one per cycle; magnitude waits for the square root unit,
//   which retires one result bit per cycle.
//   One command is in flight at a time; the next can be taken in the
//   cycle after the result is taken.
//   Reset: a clearing pass writes zero to every entry, one per cycle,
//   while s_axis_tready stays low.
//   A stalled receiver holds the result in the output register; the block
//   keeps no other item waiting until it is taken.
// ----------------------------------------------------------------------------
module complex_register_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[2:0], target_index[5:3], source_index[8:6], scalar_first[40:9],
  // scalar_second[72:41], zero fill to 80
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_real[31:0], result_imag[63:32], magnitude[95:64]
  output logic [95:0] m_axis_tdata,
  // is_magnitude[0], saturated[1]
  output logic [1:0]  m_axis_tuser
);
  import cra_pkg::*;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_RDT   = 9'b000000100,
    ST_RDS   = 9'b000001000,
    ST_MUL   = 9'b000010000,
    ST_EXEC  = 9'b000100000,
    ST_SQRT  = 9'b001000000,
    ST_OUT   = 9'b010000000,
    ST_WAIT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Register file: one synchronous memory, real part in the low half.
  logic [63:0] mem [NumRegisters];
  logic [63:0] rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [63:0]      mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  cmd_t cmd_q;
  logic signed [31:0] a_q, b_q, c_q, d_q;
  logic [AddrW-1:0] clr_q;
  logic [1:0]  mcnt_q;
  logic signed [48:0] p_q [4];
  logic signed [63:0] prod;
  logic signed [31:0] mx, my;
  res_t out_q, out_d;
  logic out_v_q;
  logic cmd_ok, needs_src;

  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic [63:0] sq_in;

  assign needs_src = (cmd_q.kind == OP_ADD) || (cmd_q.kind == OP_SUB) ||
                     (cmd_q.kind == OP_CMUL);
  assign cmd_ok = (32'(cmd_q.target_index) < NumRegisters) &&
                  (!needs_src || (32'(cmd_q.source_index) < NumRegisters));

  // Shared multiplier: step through the four products a*c, b*d, a*d, b*c
  // (or a*k, b*k for the scale operations).
  always_comb begin
    mx = a_q;
    my = c_q;
    unique case (mcnt_q)
      2'd0: begin mx = a_q; my = c_q; end
      2'd1: begin mx = b_q; my = d_q; end
      2'd2: begin mx = a_q; my = d_q; end
      default: begin mx = b_q; my = c_q; end
    endcase
  end
  assign prod = mx * my;

  assign sq_in = 64'(64'(a_q) * 64'(a_q)) + 64'(64'(b_q) * 64'(b_q));

  cra_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_in),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  logic [32:0] cr, ci;
  always_comb begin
    cr = '0;
    ci = '0;
    unique case (cmd_q.kind)
      OP_ADD: begin
        cr = clip32(50'(a_q) + 50'(c_q));
        ci = clip32(50'(b_q) + 50'(d_q));
      end
      OP_SUB: begin
        cr = clip32(50'(a_q) - 50'(c_q));
        ci = clip32(50'(b_q) - 50'(d_q));
      end
      OP_SCRE: begin
        cr = clip32(50'(p_q[0]));
        ci = clip32(50'(p_q[1]));
      end
      OP_SCIM: begin
        cr = clip32(-50'(p_q[1]));
        ci = clip32(50'(p_q[0]));
      end
      OP_CMUL: begin
        cr = clip32(50'(p_q[0]) - 50'(p_q[1]));
        ci = clip32(50'(p_q[2]) + 50'(p_q[3]));
      end
      default: begin
        cr = {1'b0, a_q};
        ci = {1'b0, b_q};
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = cmd_q.target_index[AddrW-1:0];
    mem_wdata = {ci[31:0], cr[31:0]};
    mem_raddr = cmd_q.target_index[AddrW-1:0];
    sq_start  = 1'b0;
    out_d     = out_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (32'(clr_q) == NumRegisters - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        // Read the target of the incoming item so it lands with the command.
        mem_raddr = s_axis_tdata[IdxW +: AddrW];
        if (s_axis_tvalid) state_d = ST_RDT;
      end
      ST_RDT: begin
        mem_raddr = cmd_q.source_index[AddrW-1:0];
        if (!cmd_ok) begin
          state_d = ST_IDLE;
        end else if (cmd_q.kind == OP_LOAD) begin
          mem_we    = 1'b1;
          mem_wdata = {cmd_q.scalar_second, cmd_q.scalar_first};
          state_d   = ST_IDLE;
        end else begin
          state_d = ST_RDS;
        end
      end
      ST_RDS: begin
        unique case (cmd_q.kind)
          OP_SCRE, OP_SCIM, OP_CMUL: state_d = ST_MUL;
          OP_MAG: begin
            sq_start = 1'b1;
            state_d  = ST_SQRT;
          end
          default: state_d = ST_EXEC;
        endcase
      end
      ST_MUL: begin
        if (mcnt_q == 2'd3) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        mem_we = 1'b1;
        out_d.result_real  = cr[31:0];
        out_d.result_imag  = ci[31:0];
        out_d.magnitude    = '0;
        out_d.is_magnitude = 1'b0;
        out_d.saturated    = (cmd_q.kind != OP_SHOW) && (cr[32] || ci[32]);
        state_d = ST_OUT;
      end
      ST_SQRT: begin
        if (sq_done) begin
          out_d.result_real  = '0;
          out_d.result_imag  = '0;
          out_d.magnitude    = sq_root;
          out_d.is_magnitude = 1'b1;
          out_d.saturated    = 1'b0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (!out_v_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      mcnt_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == ST_MUL) mcnt_q <= mcnt_q + 2'd1;
      else mcnt_q <= '0;
      // Hold the result until taken; load a new one when the FSM emits.
      if (state_q == ST_OUT) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) cmd_q <= cmd_t'(s_axis_tdata[72:0]);
    if (state_q == ST_RDT) begin
      a_q <= rdata_q[31:0];
      b_q <= rdata_q[63:32];
      c_q <= cmd_q.scalar_first;
      d_q <= cmd_q.scalar_first;
    end
    if (state_q == ST_RDS && needs_src) begin
      c_q <= rdata_q[31:0];
      d_q <= rdata_q[63:32];
    end
    if (state_q == ST_MUL) p_q[mcnt_q] <= qround(prod);
    if (state_q == ST_EXEC || (state_q == ST_SQRT && sq_done)) out_q <= out_d;
  end

  // Scale real: products 0 and 1 are a*k and b*k (c = d = k).
  // Scale imaginary: p0 = a*k, p1 = b*k, giving real = -b*k, imag = a*k.

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.magnitude, out_q.result_imag, out_q.result_real};
  assign m_axis_tuser  = {out_q.saturated, out_q.is_magnitude};
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the complex register ALU
// Drives random and directed commands over the input stream, predicts each
// result from a behavioral copy of the register file and compares it field by
// field with what leaves the output stream, under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import cra_pkg::*;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [31:0]        mag;
    logic               is_mag;
    logic               sat;
  } alu_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  complex_register_alu u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow register file and queue of pending results.
  logic signed [31:0] shadow_re [NumRegisters];
  logic signed [31:0] shadow_im [NumRegisters];
  alu_result_t        pending_results[$];

  int  n_errors;
  int  n_cmds;
  int  n_results;
  int  idle_pct;
  int  stall_pct;
  int  idle_cycles;
  bit  done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Round-to-nearest (ties up) Q16.16 product.
  function automatic longint q_product(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FracBits - 1));
    return p >>> FracBits;
  endfunction

  function automatic logic signed [31:0] saturate(longint v, ref logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] modulus(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root[31:0];
  endfunction

  // Update the shadow file and queue the expected result, if any.
  task automatic predict_command(op_e kind, int t, int s, logic [31:0] k1, logic [31:0] k2);
    longint      a, b, c, d, f;
    logic        sat;
    alu_result_t r;
    sat = 1'b0;
    if (t >= NumRegisters) return;
    if ((kind inside {OP_ADD, OP_SUB, OP_CMUL}) && s >= NumRegisters) return;
    a = shadow_re[t];
    b = shadow_im[t];
    c = 0;
    d = 0;
    if (kind inside {OP_ADD, OP_SUB, OP_CMUL}) begin
      c = shadow_re[s];
      d = shadow_im[s];
    end
    f = $signed(k1);
    r.re = a[31:0];
    r.im = b[31:0];
    r.mag = '0;
    r.is_mag = 1'b0;
    case (kind)
      OP_LOAD: begin
        shadow_re[t] = k1;
        shadow_im[t] = k2;
        return;
      end
      OP_ADD: begin
        r.re = saturate(a + c, sat);
        r.im = saturate(b + d, sat);
      end
      OP_SUB: begin
        r.re = saturate(a - c, sat);
        r.im = saturate(b - d, sat);
      end
      OP_SCRE: begin
        r.re = saturate(q_product(a, f), sat);
        r.im = saturate(q_product(b, f), sat);
      end
      OP_SCIM: begin
        r.re = saturate(-q_product(f, b), sat);
        r.im = saturate(q_product(f, a), sat);
      end
      OP_CMUL: begin
        r.re = saturate(q_product(a, c) - q_product(b, d), sat);
        r.im = saturate(q_product(a, d) + q_product(b, c), sat);
      end
      OP_MAG: begin
        r.mag = modulus(longint'(a * a) + longint'(b * b));
        r.re = '0;
        r.im = '0;
        r.is_mag = 1'b1;
      end
      default: ;
    endcase
    r.sat = sat;
    if (kind != OP_MAG) begin
      shadow_re[t] = r.re;
      shadow_im[t] = r.im;
    end
    pending_results.push_back(r);
  endtask

  // Send one command; hold tvalid until accepted, then predict. tvalid stays
  // high after acceptance until the next call drops it or replaces the item.
  task automatic send_command(op_e kind, int t, int s, logic [31:0] k1, logic [31:0] k2);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, k2, k1, s[2:0], t[2:0], kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_command(kind, t, s, k1, k2);
    n_cmds++;
  endtask

  // Receiver: random stalls, result checking on every accepted item.
  always @(posedge clk_i) begin
    alu_result_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $error("result with no command pending: %h %h", m_axis_tdata, m_axis_tuser);
          n_errors++;
        end else begin
          e = pending_results.pop_front();
          if (m_axis_tdata[31:0] !== e.re) begin
            $error("result_real exp %h got %h", e.re, m_axis_tdata[31:0]);
            n_errors++;
          end
          if (m_axis_tdata[63:32] !== e.im) begin
            $error("result_imag exp %h got %h", e.im, m_axis_tdata[63:32]);
            n_errors++;
          end
          if (m_axis_tdata[95:64] !== e.mag) begin
            $error("magnitude exp %h got %h", e.mag, m_axis_tdata[95:64]);
            n_errors++;
          end
          if (m_axis_tuser[0] !== e.is_mag) begin
            $error("is_magnitude exp %b got %b", e.is_mag, m_axis_tuser[0]);
            n_errors++;
          end
          if (m_axis_tuser[1] !== e.sat) begin
            $error("saturated exp %b got %b", e.sat, m_axis_tuser[1]);
            n_errors++;
          end
        end
      end
      m_axis_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: count cycles without any accepted item.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (!done && idle_cycles > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] random_scalar();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h7fffffff ^ $urandom_range(3);
      2: return 32'h80000000 | $urandom_range(3);
      3: return {{14{1'b0}}, 18'($urandom())};
      4: return {{14{1'b1}}, 18'($urandom())};
      default: return 32'($signed(16'($urandom())));
    endcase
  endfunction

  task automatic test_directed();
    op_e k;
    send_command(OP_SHOW, 0, 0, '0, '0);
    send_command(OP_LOAD, 0, 7, 32'h7fffffff, 32'h80000000);
    send_command(OP_LOAD, 5, 7, 32'h80000000, 32'h7fffffff);
    send_command(OP_ADD, 0, 0, '0, '0);
    send_command(OP_SUB, 5, 0, '0, '0);
    send_command(OP_LOAD, 1, 0, 32'h00018000, 32'hffff8000);
    send_command(OP_SCRE, 1, 0, 32'h00008000, '0);
    send_command(OP_SCIM, 1, 0, 32'hffff0000, '0);
    send_command(OP_SCRE, 0, 0, 32'h7fffffff, '0);
    send_command(OP_CMUL, 1, 1, '0, '0);
    send_command(OP_CMUL, 5, 0, '0, '0);
    send_command(OP_MAG, 5, 0, '0, '0);
    send_command(OP_MAG, 0, 0, '0, '0);
    send_command(OP_LOAD, 2, 0, 32'h80000000, 32'h80000000);
    send_command(OP_MAG, 2, 0, '0, '0);
    // ignored commands: bad target, bad source; a scale with a bad source still executes
    send_command(OP_SHOW, 6, 0, '0, '0);
    send_command(OP_LOAD, 7, 0, 32'h1, 32'h1);
    send_command(OP_ADD, 1, 6, '0, '0);
    send_command(OP_CMUL, 1, 7, '0, '0);
    send_command(OP_SCIM, 3, 7, 32'hffffffff, 32'hffffffff);
    for (int i = 0; i < 8; i++) begin
      k = op_e'(i);
      send_command(k, 4, 3, random_scalar(), random_scalar());
    end
  endtask

  task automatic test_random(int n_items, int idle, int stall);
    int t;
    int s;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n_items; i++) begin
      // mostly in-range indexes; a few out of range
      t = ($urandom_range(15) == 0) ? $urandom_range(7) : $urandom_range(NumRegisters - 1);
      s = ($urandom_range(15) == 0) ? $urandom_range(7) : $urandom_range(NumRegisters - 1);
      send_command(op_e'($urandom_range(7)), t, s, random_scalar(), random_scalar());
    end
  endtask

  initial begin
    for (int i = 0; i < NumRegisters; i++) begin
      shadow_re[i] = '0;
      shadow_im[i] = '0;
    end
    n_errors      = 0;
    n_cmds        = 0;
    n_results     = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    idle_cycles   = 0;
    done          = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400, 0, 0);
    test_random(350, 84, 0);
    test_random(350, 0, 84);
    test_random(400, 26, 26);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    done = 1'b1;
    $display("covered %0d commands (all ops, saturation, bad indexes), %0d results checked",
             n_cmds, n_results);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
